// ===== rtl/vdt_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Vector distance transform package
// Shared sizes, item types, codes, neighbour step tables and small helpers.
// ----------------------------------------------------------------------------
package vdt_pkg;

  // Grid and arithmetic sizes.
  localparam int MAX_DIM     = 16;
  localparam int OFFSET_BITS = 16;
  localparam int STORE_SIZE  = MAX_DIM * MAX_DIM * MAX_DIM;
  localparam int IDX_W       = $clog2(STORE_SIZE);
  localparam int CRD_W       = $clog2(MAX_DIM);
  localparam int DIM_W       = $clog2(MAX_DIM + 1);
  localparam int SXY_W       = $clog2(MAX_DIM * MAX_DIM + 1);
  localparam int ENTRY_W     = 3 * OFFSET_BITS;
  localparam int LEN_W       = 2 * OFFSET_BITS + 2;
  localparam int RAD_W       = LEN_W + 16;
  localparam int ROOT_W      = RAD_W / 2;
  localparam int NUM_W       = ROOT_W + 7;
  localparam int FAR_W       = 14;
  localparam int DEN_W       = FAR_W + 1;
  localparam int CFG_W       = 14;
  localparam int OFF_MAX     = 2 ** (OFFSET_BITS - 1) - 1;
  localparam int OFF_MIN     = -OFF_MAX - 1;

  // Item codes.
  typedef enum logic [1:0] {
    ACT_LOAD = 2'd0,
    ACT_RUN  = 2'd1,
    ACT_READ = 2'd2,
    ACT_NONE = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    KIND_LOAD = 2'd0,
    KIND_RUN  = 2'd1,
    KIND_READ = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    CFG_WIDTH  = 2'd0,
    CFG_HEIGHT = 2'd1,
    CFG_DEPTH  = 2'd2,
    CFG_FAR    = 2'd3
  } cfg_idx_t;

  typedef struct packed {
    action_t            action;
    logic [11:0]        address;
    logic signed [15:0] sample;
  } in_item_t;

  typedef struct packed {
    kind_t              kind;
    logic signed [15:0] signed_dist;
    logic [14:0]        abs_dist;
  } out_item_t;

  // Sequencer states.
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_V_ISS,
    ST_V_CAP,
    ST_V_LEN,
    ST_N_ISS,
    ST_N_CAP,
    ST_N_LEN,
    ST_V_WR,
    ST_R_CAP,
    ST_R_LEN_A,
    ST_R_SQRT_A,
    ST_R_LEN_B,
    ST_R_SQRT_B,
    ST_R_DIV,
    ST_FIN
  } st_t;

  // One neighbour step.
  typedef struct packed {
    logic signed [1:0] dx;
    logic signed [1:0] dy;
    logic signed [1:0] dz;
  } delta_t;

  localparam delta_t D_XM = '{dx: -2'sd1, dy: 2'sd0, dz: 2'sd0};
  localparam delta_t D_XP = '{dx: 2'sd1, dy: 2'sd0, dz: 2'sd0};
  localparam delta_t D_YM = '{dx: 2'sd0, dy: -2'sd1, dz: 2'sd0};
  localparam delta_t D_YP = '{dx: 2'sd0, dy: 2'sd1, dz: 2'sd0};
  localparam delta_t D_ZM = '{dx: 2'sd0, dy: 2'sd0, dz: -2'sd1};
  localparam delta_t D_ZP = '{dx: 2'sd0, dy: 2'sd0, dz: 2'sd1};

  // Neighbour step i of row mask m in the forward or backward sweep.
  function automatic delta_t nb_delta(input logic bwd, input logic [1:0] m,
                                      input logic [1:0] i);
    delta_t d;
    d = D_XM;
    case ({bwd, m, i})
      5'b0_00_00: d = D_XM;
      5'b0_00_01: d = D_ZM;
      5'b0_00_10: d = D_YM;
      5'b0_01_00: d = D_YM;
      5'b0_01_01: d = D_XP;
      5'b0_10_00: d = D_YP;
      5'b0_10_01: d = D_XP;
      5'b0_11_00: d = D_YP;
      5'b0_11_01: d = D_XM;
      5'b1_00_00: d = D_YP;
      5'b1_00_01: d = D_XP;
      5'b1_00_10: d = D_ZP;
      5'b1_01_00: d = D_YP;
      5'b1_01_01: d = D_XM;
      5'b1_10_00: d = D_XM;
      5'b1_10_01: d = D_YM;
      5'b1_11_00: d = D_YM;
      5'b1_11_01: d = D_XP;
      default:    d = D_XM;
    endcase
    return d;
  endfunction

  // The first row mask tries three neighbours, the others two.
  function automatic logic [1:0] nb_count(input logic [1:0] m);
    return (m == 2'd0) ? 2'd3 : 2'd2;
  endfunction

  // Saturate a widened offset component to the offset range.
  function automatic logic signed [OFFSET_BITS-1:0] sat_off(
      input logic signed [OFFSET_BITS:0] v);
    logic signed [OFFSET_BITS-1:0] r;
    if (v > (OFFSET_BITS + 1)'(OFF_MAX)) r = OFFSET_BITS'(OFF_MAX);
    else if (v < (OFFSET_BITS + 1)'(OFF_MIN)) r = OFFSET_BITS'(OFF_MIN);
    else r = OFFSET_BITS'(v);
    return r;
  endfunction

  // Dimension register to dimension in use: zero acts as one.
  function automatic logic [DIM_W-1:0] clamp_dim(input logic [4:0] v);
    logic [DIM_W-1:0] r;
    if (v == 5'd0) r = DIM_W'(1);
    else if (int'(v) > MAX_DIM) r = DIM_W'(MAX_DIM);
    else r = DIM_W'(v);
    return r;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/vdt_grid_ram.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Offset grid memory
// One offset triple per voxel; one write port and one registered read port.
// ----------------------------------------------------------------------------
module vdt_grid_ram
  import vdt_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               we,
  input  wire logic [IDX_W-1:0]   waddr,
  input  wire logic [ENTRY_W-1:0] wdata,
  input  wire logic [IDX_W-1:0]   raddr,
  output logic      [ENTRY_W-1:0] rdata
);

  logic [ENTRY_W-1:0] mem [STORE_SIZE];

  // Write when enabled; the read data is registered.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ===== rtl/vdt_sqrt.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Iterative integer square root
// Floor square root, one result bit per cycle, restoring digit recurrence.
// ----------------------------------------------------------------------------
module vdt_sqrt
  import vdt_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  input  wire logic [RAD_W-1:0]  rad,
  output logic                   done,
  output logic      [ROOT_W-1:0] root
);

  localparam int CNT_W = $clog2(ROOT_W + 1);

  logic              busy_r;
  logic              done_r;
  logic [CNT_W-1:0]  cnt_r;
  logic [RAD_W-1:0]  rad_r;
  logic [ROOT_W+1:0] rem_r;
  logic [ROOT_W-1:0] root_r;
  logic [ROOT_W+1:0] rem_sh;
  logic [ROOT_W+1:0] trial;
  logic              ge;

  // One recurrence step: bring down two radicand bits and try a one.
  always_comb begin
    rem_sh = {rem_r[ROOT_W-1:0], rad_r[RAD_W-1 -: 2]};
    trial  = {root_r, 2'b01};
    ge     = (rem_sh >= trial);
  end

  // Step counter and completion pulse.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        if (cnt_r == CNT_W'(ROOT_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end else begin
          cnt_r <= cnt_r + CNT_W'(1);
        end
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    if (start) begin
      rad_r  <= rad;
      rem_r  <= '0;
      root_r <= '0;
    end else if (busy_r) begin
      rad_r <= rad_r << 2;
      if (ge) begin
        rem_r  <= rem_sh - trial;
        root_r <= {root_r[ROOT_W-2:0], 1'b1};
      end else begin
        rem_r  <= rem_sh;
        root_r <= {root_r[ROOT_W-2:0], 1'b0};
      end
    end
  end

  assign done = done_r;
  assign root = root_r;

endmodule
`default_nettype wire

// ===== rtl/vdt_div.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Iterative unsigned divider
// Restoring division, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module vdt_div
  import vdt_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  input  wire logic [NUM_W-1:0] num,
  input  wire logic [DEN_W-1:0] den,
  output logic                  done,
  output logic      [NUM_W-1:0] quo
);

  localparam int CNT_W = $clog2(NUM_W + 1);

  logic             busy_r;
  logic             done_r;
  logic [CNT_W-1:0] cnt_r;
  logic [NUM_W-1:0] quo_r;
  logic [DEN_W-1:0] den_r;
  logic [DEN_W-1:0] rem_r;
  logic [DEN_W:0]   rem_sh;
  logic             ge;

  // Shift in the next numerator bit and compare with the divisor.
  always_comb begin
    rem_sh = {rem_r, quo_r[NUM_W-1]};
    ge     = (rem_sh >= {1'b0, den_r});
  end

  // Step counter and completion pulse.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        if (cnt_r == CNT_W'(NUM_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end else begin
          cnt_r <= cnt_r + CNT_W'(1);
        end
      end
    end
  end

  // Datapath registers: the quotient shifts in where the numerator leaves.
  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= num;
      den_r <= den;
      rem_r <= '0;
    end else if (busy_r) begin
      if (ge) begin
        rem_r <= DEN_W'(rem_sh - {1'b0, den_r});
        quo_r <= {quo_r[NUM_W-2:0], 1'b1};
      end else begin
        rem_r <= rem_sh[DEN_W-1:0];
        quo_r <= {quo_r[NUM_W-2:0], 1'b0};
      end
    end
  end

  assign done = done_r;
  assign quo  = quo_r;

endmodule
`default_nettype wire

// ===== rtl/vector_distance_transform_3d.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// 3-D signed vector distance transform
// Two offset grids in block memory, swept in raster order by a sequencer.
// ----------------------------------------------------------------------------
// Usage: configure grid_width/height/depth and far_value through the cfg port
// while the block is idle. Each input item carries an action:
//   load: seeds both offset grids at the address if it is in range; answered
//     in the cycle after acceptance with a kind-load item.
//   run: forward and backward sweeps over both grids; each visit reads the
//     voxel's offset, then each in-grid neighbour in turn, through the single
//     read port of each grid memory. A run takes 2*2*4*W*H*D visits, then
//     answers with a kind-run item.
//   read: both lengths, two square roots and a rounded divide.
// One item is processed at a time; a load is taken every cycle as long as
// results drain. Results leave through an output register: while the
// receiver stalls, a finished result waits there and no new item is taken.
// Reset clears the sequencer and output valid and sets the configuration
// registers to their defaults; grid contents are undefined until loaded.
// ----------------------------------------------------------------------------
module vector_distance_transform_3d
  import vdt_pkg::*;
(
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_valid,
  output logic                in_ready,
  input  wire in_item_t       in_data,
  output logic                out_valid,
  input  wire logic           out_ready,
  output out_item_t           out_data,
  input  wire logic           cfg_we,
  input  wire cfg_idx_t       cfg_index,
  input  wire logic [CFG_W-1:0] cfg_wdata
);

  // Configuration registers.
  logic [4:0]       width_r, height_r, depth_r;
  logic [FAR_W-1:0] far_r;

  // Sequencer and datapath registers.
  st_t              st_r, st_nxt;
  logic             g_r, g_nxt;
  logic             bwd_r, bwd_nxt;
  logic [1:0]       m_r, m_nxt;
  logic [CRD_W-1:0] x_r, x_nxt, y_r, y_nxt, z_r, z_nxt;
  logic [1:0]       nb_i_r, nb_i_nxt;
  logic [1:0]       sq_k_r, sq_k_nxt;
  logic [LEN_W-1:0] acc_r, acc_nxt, curlen_r, curlen_nxt;
  logic [ENTRY_W-1:0] cur_r, cur_nxt, cand_r, cand_nxt, sq_vec_r, sq_vec_nxt;
  logic [ENTRY_W-1:0] b_hold_r, b_hold_nxt;
  logic [ROOT_W-1:0]  s1_r, s1_nxt;
  logic             neg_r, neg_nxt;
  logic [IDX_W-1:0] cur_idx_r, cur_idx_nxt;
  logic [DIM_W-1:0] sx_r, sx_nxt, sy_r, sy_nxt, sz_r, sz_nxt;
  logic [SXY_W-1:0] sxy_r, sxy_nxt;
  out_item_t        res_r, res_nxt, out_r, out_nxt;
  logic             out_valid_r, out_valid_nxt;

  // Memory ports.
  logic               we_a, we_b;
  logic [IDX_W-1:0]   waddr, raddr;
  logic [ENTRY_W-1:0] wdata_a, wdata_b, rd_a, rd_b, rd_sel;

  // Arithmetic units.
  logic              sqrt_start, sqrt_done, div_start, div_done;
  logic [ROOT_W-1:0] sqrt_root;
  logic [NUM_W-1:0]  div_num, div_quo;
  logic [DEN_W-1:0]  div_den;

  // Combinational helpers.
  logic                    in_acc, in_range, interior;
  logic [IDX_W-1:0]        in_idx, cur_vidx, nb_vidx;
  logic signed [OFFSET_BITS-1:0] seed;
  logic [ENTRY_W-1:0]      entry_far;
  delta_t                  dl;
  logic signed [1:0]       dcomp [3];
  logic [CRD_W+1:0]        nx, ny, nz;
  logic                    nb_ok;
  logic [ENTRY_W-1:0]      cand_c;
  logic signed [OFFSET_BITS-1:0] sq_comp;
  logic signed [2*OFFSET_BITS-1:0] sq_prod;
  logic [LEN_W-1:0]        acc_sum;
  logic [ROOT_W-1:0]       mag;
  logic [FAR_W-1:0]        fdiv;
  logic                    neg_c;
  logic signed [15:0]      rd_sd;
  logic [14:0]             rd_ad;

  // Raster direction of a row mask.
  function automatic logic up_x(input logic b, input logic [1:0] mm);
    return ((mm == 2'd0) || (mm == 2'd3)) ^ b;
  endfunction

  function automatic logic up_y(input logic b, input logic [1:0] mm);
    return (!mm[1]) ^ b;
  endfunction

  function automatic logic [CRD_W-1:0] first_c(input logic up,
                                                input logic [DIM_W-1:0] s);
    return up ? '0 : CRD_W'(s - DIM_W'(1));
  endfunction

  function automatic logic [CRD_W-1:0] last_c(input logic up,
                                               input logic [DIM_W-1:0] s);
    return up ? CRD_W'(s - DIM_W'(1)) : '0;
  endfunction

  function automatic logic [CRD_W-1:0] step_c(input logic [CRD_W-1:0] v,
                                               input logic up);
    return up ? v + CRD_W'(1) : v - CRD_W'(1);
  endfunction

  function automatic logic [IDX_W-1:0] vidx(input logic [CRD_W-1:0] vx,
                                            input logic [CRD_W-1:0] vy,
                                            input logic [CRD_W-1:0] vz,
                                            input logic [DIM_W-1:0] s,
                                            input logic [SXY_W-1:0] sxy);
    return IDX_W'(vx) + IDX_W'(vy) * IDX_W'(s) + IDX_W'(vz) * IDX_W'(sxy);
  endfunction

  // Grid memories.
  vdt_grid_ram u_ram_a (
    .clk   (clk),
    .we    (we_a),
    .waddr (waddr),
    .wdata (wdata_a),
    .raddr (raddr),
    .rdata (rd_a)
  );

  vdt_grid_ram u_ram_b (
    .clk   (clk),
    .we    (we_b),
    .waddr (waddr),
    .wdata (wdata_b),
    .raddr (raddr),
    .rdata (rd_b)
  );

  vdt_sqrt u_sqrt (
    .clk   (clk),
    .rst_n (rst_n),
    .start (sqrt_start),
    .rad   ({acc_sum, 16'b0}),
    .done  (sqrt_done),
    .root  (sqrt_root)
  );

  vdt_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quo   (div_quo)
  );

  // Input decode and load seeds.
  always_comb begin
    in_ready = (st_r == ST_IDLE) && (!out_valid_r || out_ready);
    in_acc   = in_valid && in_ready;
    in_range = (int'(in_data.address) < STORE_SIZE);
    in_idx   = IDX_W'(in_data.address);
    interior = !in_data.sample[15];
    if (int'(far_r) > OFF_MAX) seed = OFFSET_BITS'(OFF_MAX);
    else seed = OFFSET_BITS'(far_r);
    entry_far = {3{seed}};
  end

  // Neighbour address and candidate offset.
  always_comb begin
    rd_sel   = g_r ? rd_b : rd_a;
    dl       = nb_delta(bwd_r, m_r, nb_i_r);
    dcomp[0] = dl.dx;
    dcomp[1] = dl.dy;
    dcomp[2] = dl.dz;
    nx = {2'b00, x_r} + (CRD_W + 2)'(dl.dx);
    ny = {2'b00, y_r} + (CRD_W + 2)'(dl.dy);
    nz = {2'b00, z_r} + (CRD_W + 2)'(dl.dz);
    nb_ok = !nx[CRD_W+1] && (nx < (CRD_W + 2)'(sx_r)) &&
            !ny[CRD_W+1] && (ny < (CRD_W + 2)'(sy_r)) &&
            !nz[CRD_W+1] && (nz < (CRD_W + 2)'(sz_r));
    cur_vidx = vidx(x_r, y_r, z_r, sx_r, sxy_r);
    nb_vidx  = vidx(nx[CRD_W-1:0], ny[CRD_W-1:0], nz[CRD_W-1:0], sx_r, sxy_r);
    for (int c = 0; c < 3; c++) begin
      cand_c[c*OFFSET_BITS +: OFFSET_BITS] =
        sat_off($signed({rd_sel[c*OFFSET_BITS+OFFSET_BITS-1],
                         rd_sel[c*OFFSET_BITS +: OFFSET_BITS]}) +
                (OFFSET_BITS + 1)'(dcomp[c]));
    end
  end

  // Squared length, one component per cycle.
  always_comb begin
    case (sq_k_r)
      2'd0:    sq_comp = sq_vec_r[0 +: OFFSET_BITS];
      2'd1:    sq_comp = sq_vec_r[OFFSET_BITS +: OFFSET_BITS];
      default: sq_comp = sq_vec_r[2*OFFSET_BITS +: OFFSET_BITS];
    endcase
    sq_prod = sq_comp * sq_comp;
    acc_sum = acc_r + LEN_W'($unsigned(sq_prod));
  end

  // Read result: divider operands and rounding to the output range.
  always_comb begin
    neg_c   = (s1_r < sqrt_root);
    mag     = neg_c ? sqrt_root - s1_r : s1_r - sqrt_root;
    fdiv    = (far_r == '0) ? FAR_W'(1) : far_r;
    div_num = NUM_W'({mag, 6'b0}) + NUM_W'(fdiv);
    div_den = {fdiv, 1'b0};
    if (neg_r) begin
      rd_sd = (div_quo > NUM_W'(32768)) ? 16'sh8000 : 16'(~div_quo + NUM_W'(1));
      rd_ad = (div_quo >= NUM_W'(32768)) ? 15'h7FFF : div_quo[14:0];
    end else begin
      rd_sd = (div_quo > NUM_W'(32767)) ? 16'sh7FFF : div_quo[15:0];
      rd_ad = (div_quo > NUM_W'(32767)) ? 15'h7FFF : div_quo[14:0];
    end
  end

  // Sequencer: next state, memory control and output register.
  always_comb begin
    st_nxt        = st_r;
    g_nxt         = g_r;
    bwd_nxt       = bwd_r;
    m_nxt         = m_r;
    x_nxt         = x_r;
    y_nxt         = y_r;
    z_nxt         = z_r;
    nb_i_nxt      = nb_i_r;
    sq_k_nxt      = sq_k_r;
    acc_nxt       = acc_r;
    curlen_nxt    = curlen_r;
    cur_nxt       = cur_r;
    cand_nxt      = cand_r;
    sq_vec_nxt    = sq_vec_r;
    b_hold_nxt    = b_hold_r;
    s1_nxt        = s1_r;
    neg_nxt       = neg_r;
    cur_idx_nxt   = cur_idx_r;
    sx_nxt        = sx_r;
    sy_nxt        = sy_r;
    sz_nxt        = sz_r;
    sxy_nxt       = sxy_r;
    res_nxt       = res_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && !out_ready;
    we_a          = 1'b0;
    we_b          = 1'b0;
    waddr         = cur_idx_r;
    wdata_a       = cur_r;
    wdata_b       = cur_r;
    raddr         = in_idx;
    sqrt_start    = 1'b0;
    div_start     = 1'b0;

    unique case (st_r)
      ST_IDLE: begin
        if (in_acc) begin
          unique case (in_data.action)
            ACT_LOAD: begin
              if (in_range) begin
                we_a    = 1'b1;
                we_b    = 1'b1;
                waddr   = in_idx;
                wdata_a = interior ? '0 : entry_far;
                wdata_b = interior ? entry_far : '0;
              end
              out_nxt       = '{kind: KIND_LOAD, signed_dist: '0, abs_dist: '0};
              out_valid_nxt = 1'b1;
            end
            ACT_RUN: begin
              sx_nxt  = clamp_dim(width_r);
              sy_nxt  = clamp_dim(height_r);
              sz_nxt  = clamp_dim(depth_r);
              sxy_nxt = SXY_W'(clamp_dim(width_r)) * SXY_W'(clamp_dim(height_r));
              g_nxt   = 1'b0;
              bwd_nxt = 1'b0;
              m_nxt   = 2'd0;
              x_nxt   = '0;
              y_nxt   = '0;
              z_nxt   = '0;
              st_nxt  = ST_V_ISS;
            end
            ACT_READ: begin
              if (in_range) begin
                st_nxt = ST_R_CAP;
              end else begin
                out_nxt       = '{kind: KIND_READ, signed_dist: '0, abs_dist: '0};
                out_valid_nxt = 1'b1;
              end
            end
            default: ;
          endcase
        end
      end

      // Visit: fetch the voxel's own offset and its length.
      ST_V_ISS: begin
        raddr       = cur_vidx;
        cur_idx_nxt = cur_vidx;
        st_nxt      = ST_V_CAP;
      end
      ST_V_CAP: begin
        cur_nxt    = rd_sel;
        sq_vec_nxt = rd_sel;
        acc_nxt    = '0;
        sq_k_nxt   = 2'd0;
        st_nxt     = ST_V_LEN;
      end
      ST_V_LEN: begin
        acc_nxt  = acc_sum;
        sq_k_nxt = sq_k_r + 2'd1;
        if (sq_k_r == 2'd2) begin
          curlen_nxt = acc_sum;
          nb_i_nxt   = 2'd0;
          st_nxt     = ST_N_ISS;
        end
      end

      // Neighbours: skip those outside the grid, keep a shorter candidate.
      ST_N_ISS: begin
        if (nb_i_r == nb_count(m_r)) begin
          st_nxt = ST_V_WR;
        end else if (!nb_ok) begin
          nb_i_nxt = nb_i_r + 2'd1;
        end else begin
          raddr  = nb_vidx;
          st_nxt = ST_N_CAP;
        end
      end
      ST_N_CAP: begin
        cand_nxt   = cand_c;
        sq_vec_nxt = cand_c;
        acc_nxt    = '0;
        sq_k_nxt   = 2'd0;
        st_nxt     = ST_N_LEN;
      end
      ST_N_LEN: begin
        acc_nxt  = acc_sum;
        sq_k_nxt = sq_k_r + 2'd1;
        if (sq_k_r == 2'd2) begin
          if (acc_sum < curlen_r) begin
            cur_nxt    = cand_r;
            curlen_nxt = acc_sum;
          end
          nb_i_nxt = nb_i_r + 2'd1;
          st_nxt   = ST_N_ISS;
        end
      end

      // Write back and step the raster order.
      ST_V_WR: begin
        we_a   = !g_r;
        we_b   = g_r;
        st_nxt = ST_V_ISS;
        if (x_r != last_c(up_x(bwd_r, m_r), sx_r)) begin
          x_nxt = step_c(x_r, up_x(bwd_r, m_r));
        end else if (!m_r[0]) begin
          m_nxt = m_r + 2'd1;
          x_nxt = first_c(up_x(bwd_r, m_r + 2'd1), sx_r);
        end else if (y_r != last_c(up_y(bwd_r, m_r), sy_r)) begin
          y_nxt = step_c(y_r, up_y(bwd_r, m_r));
          m_nxt = m_r - 2'd1;
          x_nxt = first_c(up_x(bwd_r, m_r - 2'd1), sx_r);
        end else if (m_r == 2'd1) begin
          m_nxt = 2'd2;
          y_nxt = first_c(up_y(bwd_r, 2'd2), sy_r);
          x_nxt = first_c(up_x(bwd_r, 2'd2), sx_r);
        end else if (z_r != last_c(!bwd_r, sz_r)) begin
          z_nxt = step_c(z_r, !bwd_r);
          m_nxt = 2'd0;
          y_nxt = first_c(up_y(bwd_r, 2'd0), sy_r);
          x_nxt = first_c(up_x(bwd_r, 2'd0), sx_r);
        end else if (!bwd_r || !g_r) begin
          bwd_nxt = !bwd_r;
          g_nxt   = g_r ^ bwd_r;
          m_nxt   = 2'd0;
          z_nxt   = first_c(bwd_r, sz_r);
          y_nxt   = first_c(up_y(!bwd_r, 2'd0), sy_r);
          x_nxt   = first_c(up_x(!bwd_r, 2'd0), sx_r);
        end else begin
          res_nxt = '{kind: KIND_RUN, signed_dist: '0, abs_dist: '0};
          st_nxt  = ST_FIN;
        end
      end

      // Read: two lengths, two roots, one rounded division.
      ST_R_CAP: begin
        b_hold_nxt = rd_b;
        sq_vec_nxt = rd_a;
        acc_nxt    = '0;
        sq_k_nxt   = 2'd0;
        st_nxt     = ST_R_LEN_A;
      end
      ST_R_LEN_A: begin
        acc_nxt  = acc_sum;
        sq_k_nxt = sq_k_r + 2'd1;
        if (sq_k_r == 2'd2) begin
          sqrt_start = 1'b1;
          st_nxt     = ST_R_SQRT_A;
        end
      end
      ST_R_SQRT_A: begin
        if (sqrt_done) begin
          s1_nxt     = sqrt_root;
          sq_vec_nxt = b_hold_r;
          acc_nxt    = '0;
          sq_k_nxt   = 2'd0;
          st_nxt     = ST_R_LEN_B;
        end
      end
      ST_R_LEN_B: begin
        acc_nxt  = acc_sum;
        sq_k_nxt = sq_k_r + 2'd1;
        if (sq_k_r == 2'd2) begin
          sqrt_start = 1'b1;
          st_nxt     = ST_R_SQRT_B;
        end
      end
      ST_R_SQRT_B: begin
        if (sqrt_done) begin
          div_start = 1'b1;
          neg_nxt   = neg_c;
          st_nxt    = ST_R_DIV;
        end
      end
      ST_R_DIV: begin
        if (div_done) begin
          res_nxt = '{kind: KIND_READ, signed_dist: rd_sd, abs_dist: rd_ad};
          st_nxt  = ST_FIN;
        end
      end

      // Hand the result to the output register once it is free.
      ST_FIN: begin
        if (!out_valid_r || out_ready) begin
          out_nxt       = res_r;
          out_valid_nxt = 1'b1;
          st_nxt        = ST_IDLE;
        end
      end

      default: st_nxt = ST_IDLE;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      st_r        <= st_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    g_r       <= g_nxt;
    bwd_r     <= bwd_nxt;
    m_r       <= m_nxt;
    x_r       <= x_nxt;
    y_r       <= y_nxt;
    z_r       <= z_nxt;
    nb_i_r    <= nb_i_nxt;
    sq_k_r    <= sq_k_nxt;
    acc_r     <= acc_nxt;
    curlen_r  <= curlen_nxt;
    cur_r     <= cur_nxt;
    cand_r    <= cand_nxt;
    sq_vec_r  <= sq_vec_nxt;
    b_hold_r  <= b_hold_nxt;
    s1_r      <= s1_nxt;
    neg_r     <= neg_nxt;
    cur_idx_r <= cur_idx_nxt;
    sx_r      <= sx_nxt;
    sy_r      <= sy_nxt;
    sz_r      <= sz_nxt;
    sxy_r     <= sxy_nxt;
    res_r     <= res_nxt;
    out_r     <= out_nxt;
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= 5'd16;
      height_r <= 5'd16;
      depth_r  <= 5'd16;
      far_r    <= FAR_W'(1024);
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_WIDTH:  width_r  <= cfg_wdata[4:0];
        CFG_HEIGHT: height_r <= cfg_wdata[4:0];
        CFG_DEPTH:  depth_r  <= cfg_wdata[4:0];
        CFG_FAR:    far_r    <= cfg_wdata[FAR_W-1:0];
        default: ;
      endcase
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // A load is answered in the very next cycle.
  a_load_answer: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && in_data.action == ACT_LOAD) |=>
      (out_valid && out_data.kind == KIND_LOAD))
    else $error("load item not answered in the next cycle");

  // Root results only arrive while a read waits for them.
  a_sqrt_owner: assert property (@(posedge clk) disable iff (!rst_n)
    sqrt_done |-> (st_r == ST_R_SQRT_A || st_r == ST_R_SQRT_B))
    else $error("square root finished outside a read");

  // The divider only finishes while a read waits for it.
  a_div_owner: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> (st_r == ST_R_DIV))
    else $error("division finished outside a read");

endmodule
`default_nettype wire
